// ===== design/pidaw_pkg.sv =====
// Shared types, widths, register indexes and the microcode ROM of the PID controller.
// No dependencies; every other design file imports this package.
package pidaw_pkg;

    localparam int DW   = 16;          // sample and drive width
    localparam int EW   = DW + 1;      // error width
    localparam int GW   = 16;          // gain width, unsigned Q8.8
    localparam int FRAC = 8;           // fractional bits of the gains
    localparam int LW   = 15;          // drive limit width
    localparam int IW   = 25;          // integral accumulator width
    localparam int QW   = LW + FRAC;   // width of the integral bound
    localparam int PW   = GW + 1 + IW; // product width
    localparam int AW   = PW + 2;      // accumulator width, three products
    localparam int VW   = AW - FRAC + 1; // unlimited drive width
    localparam int CIW  = 3;           // configuration index width
    localparam int PCW  = 4;           // microcode address width

    localparam logic [CIW-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [CIW-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [CIW-1:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [CIW-1:0] REG_SETPOINT    = 3'd3;
    localparam logic [CIW-1:0] REG_DRIVE_LIMIT = 3'd4;
    localparam logic [CIW-1:0] REG_LOOP_MODE   = 3'd5;

    localparam logic [LW-1:0] LIMIT_RESET = 15'h7FFF;

    // microcode entry points
    localparam logic [PCW-1:0] A_DISP = 4'd0;
    localparam logic [PCW-1:0] A_INC  = 4'd6;
    localparam logic [PCW-1:0] A_TAIL = 4'd9;
    localparam logic [PCW-1:0] A_CLR  = 4'd12;

    typedef enum logic [1:0] {G_KP, G_KI, G_KD} t_gsel;
    typedef enum logic [1:0] {O_ERR, O_INTEG, O_D1, O_D2} t_osel;
    typedef enum logic [1:0] {J_NEXT, J_GOTO, J_DISP, J_END} t_jmp;

    typedef struct packed {
        logic           prep;        // form error differences, clear accumulator
        logic           integ_add;   // integrate with anti-windup hold
        logic           integ_clamp; // bound integral to +/- imax
        logic           mul;         // load product register
        t_gsel          gsel;
        t_osel          osel;
        logic           acc;         // add product register to accumulator
        logic           sum;         // scale and add base value
        logic           fin;         // limit, emit result, update history
        logic           clr_out;     // emit zero drive, clear history
        t_jmp           jmp;
        logic [PCW-1:0] addr;
    } t_uop;

    localparam t_uop UOP_NOP = t_uop'(0);

    function automatic t_uop uop_rom(input logic [PCW-1:0] pc);
        t_uop u;
        u = UOP_NOP;
        case (pc)
            4'd0: begin
                u.prep = 1'b1;
                u.jmp  = J_DISP;
            end
            4'd1: u.integ_add = 1'b1;
            4'd2: u.integ_clamp = 1'b1;
            4'd3: begin
                u.mul  = 1'b1; u.gsel = G_KP; u.osel = O_ERR;
            end
            4'd4: begin
                u.mul  = 1'b1; u.gsel = G_KI; u.osel = O_INTEG; u.acc = 1'b1;
            end
            4'd5: begin
                u.mul  = 1'b1; u.gsel = G_KD; u.osel = O_D1; u.acc = 1'b1;
                u.jmp  = J_GOTO; u.addr = A_TAIL;
            end
            4'd6: begin
                u.mul  = 1'b1; u.gsel = G_KP; u.osel = O_D1;
            end
            4'd7: begin
                u.mul  = 1'b1; u.gsel = G_KI; u.osel = O_ERR; u.acc = 1'b1;
            end
            4'd8: begin
                u.mul  = 1'b1; u.gsel = G_KD; u.osel = O_D2; u.acc = 1'b1;
            end
            4'd9:  u.acc = 1'b1;
            4'd10: u.sum = 1'b1;
            4'd11: begin
                u.fin = 1'b1;
                u.jmp = J_END;
            end
            4'd12: begin
                u.clr_out = 1'b1;
                u.jmp     = J_END;
            end
            default: u.jmp = J_END;
        endcase
        return u;
    endfunction

endpackage

// ===== design/pid_controller_antiwindup_top.sv =====
// PID controller with anti-windup, positional or incremental form: top level.
// Holds configuration and output register; uses pidaw_pkg, pidaw_div,
// pidaw_useq and pidaw_datapath.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata measured, feedforward; tuser clear
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata drive, loop_error; tuser saturated
//   cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// A sample runs 9 microcode steps in positional mode, 7 in incremental mode and 2 on
// clear, on one shared 17x25 multiplier.
// The next sample is taken once the program ends, even while a result waits.
// Writing gain_integ or drive_limit starts a divider run for the integral bound;
// s_axis_tready stays low until that run has finished.
// Reset is synchronous, active low; no clearing pass is needed.
// A result that is not taken holds the final step and the step counter.
module pid_controller_antiwindup_top
    import pidaw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [31:0]    s_axis_tdata,   // [15:0] measured, [31:16] feedforward
    input  logic           s_axis_tuser,   // [0] clear
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [39:0]    m_axis_tdata,   // [15:0] drive, [32:16] loop_error, zero fill
    output logic           m_axis_tuser,   // [0] saturated
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [CIW-1:0] i_cfg_index,
    input  logic [15:0]    i_cfg_data
);

    logic        [GW-1:0] r_kp, r_ki, r_kd;
    logic signed [DW-1:0] r_sp;
    logic        [LW-1:0] r_lim;
    logic                 r_mode;
    logic                 r_div_kick;

    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_drive;
    logic                 r_out_sat;
    logic signed [EW-1:0] r_out_err;

    logic                 w_cfg_wr;
    logic                 w_div_busy;
    logic        [QW-1:0] w_imax;
    logic                 w_seq_busy;
    t_uop                 w_uop;
    logic                 w_accept;
    logic                 w_emit;
    logic                 w_stall;
    logic                 w_out_en;
    logic signed [DW-1:0] w_drive;
    logic                 w_sat;
    logic signed [EW-1:0] w_err;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_sp       <= '0;
            r_lim      <= LIMIT_RESET;
            r_mode     <= 1'b0;
            r_div_kick <= 1'b0;
        end else begin
            r_div_kick <= w_cfg_wr && (i_cfg_index == REG_GAIN_INTEG
                                    || i_cfg_index == REG_DRIVE_LIMIT);
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    REG_GAIN_PROP:   r_kp   <= i_cfg_data;
                    REG_GAIN_INTEG:  r_ki   <= i_cfg_data;
                    REG_GAIN_DERIV:  r_kd   <= i_cfg_data;
                    REG_SETPOINT:    r_sp   <= i_cfg_data;
                    REG_DRIVE_LIMIT: r_lim  <= i_cfg_data[LW-1:0];
                    REG_LOOP_MODE:   r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    pidaw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_kick),
        .i_dividend ({r_lim, {FRAC{1'b0}}}),
        .i_divisor  (r_ki),
        .o_busy     (w_div_busy),
        .o_quot     (w_imax)
    );

    assign s_axis_tready = !w_seq_busy && !r_div_kick && !w_div_busy;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    // hold the final step while the previous result is still waiting
    assign w_emit   = w_uop.fin | w_uop.clr_out;
    assign w_stall  = w_emit && r_out_valid && !m_axis_tready;
    assign w_out_en = w_emit && !w_stall;

    pidaw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_clear (s_axis_tuser),
        .i_mode  (r_mode),
        .i_stall (w_stall),
        .o_busy  (w_seq_busy),
        .o_uop   (w_uop)
    );

    pidaw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_measured    (s_axis_tdata[15:0]),
        .i_feedforward (s_axis_tdata[31:16]),
        .i_setpoint    (r_sp),
        .i_kp          (r_kp),
        .i_ki          (r_ki),
        .i_kd          (r_kd),
        .i_lim         (r_lim),
        .i_mode        (r_mode),
        .i_imax        (w_imax),
        .i_uop         (w_uop),
        .i_stall       (w_stall),
        .o_drive       (w_drive),
        .o_sat         (w_sat),
        .o_err         (w_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_en) begin
            r_out_drive <= w_drive;
            r_out_sat   <= w_sat;
            r_out_err   <= w_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_err, r_out_drive};
    assign m_axis_tuser  = r_out_sat;

    a_no_accept_during_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_kick || w_div_busy) |-> !s_axis_tready)
        else $error("sample taken while integral bound is being computed");

    a_accept_starts_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_seq_busy)
        else $error("sequencer did not start after a transfer");

    a_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_en |-> w_seq_busy)
        else $error("result written with no program running");

    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_drive <= $signed({1'b0, r_lim})
                      && r_out_drive >= -$signed({1'b0, r_lim})))
        else $error("drive beyond limit");

endmodule

// ===== design/pidaw_div.sv =====
// Restoring divider for the integral bound imax = (drive_limit << 8) / gain_integ.
// One quotient bit per cycle; depends on pidaw_pkg.
module pidaw_div
    import pidaw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_dividend,
    input  logic [GW-1:0] i_divisor,
    output logic          o_busy,
    output logic [QW-1:0] o_quot
);

    localparam int CW = $clog2(QW);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [GW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [GW:0]   w_shift;
    logic [GW+1:0] w_diff;

    assign w_shift = {r_rem, r_quo[QW-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(QW - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (!w_diff[GW+1]) begin
                n_rem = w_diff[GW-1:0];
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = w_shift[GW-1:0];
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

// ===== design/pidaw_useq.sv =====
// Microcode sequencer: step counter, ROM lookup and jump handling.
// Depends on pidaw_pkg for the control word and the ROM.
module pidaw_useq
    import pidaw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_clear,
    input  logic i_mode,
    input  logic i_stall,
    output logic o_busy,
    output t_uop o_uop
);

    logic           r_busy, n_busy;
    logic [PCW-1:0] r_pc, n_pc;
    logic           r_clr, n_clr;
    t_uop           w_uop;

    assign w_uop = uop_rom(r_pc);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_clr  = r_clr;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = A_DISP;
            n_clr  = i_clear;
        end else if (r_busy && !i_stall) begin
            unique case (w_uop.jmp)
                J_NEXT: n_pc = r_pc + 1'b1;
                J_GOTO: n_pc = w_uop.addr;
                J_DISP: begin
                    if (r_clr) begin
                        n_pc = A_CLR;
                    end else if (i_mode) begin
                        n_pc = A_INC;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
                J_END: n_busy = 1'b0;
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= A_DISP;
            r_clr  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_clr  <= n_clr;
        end
    end

    assign o_busy = r_busy;
    assign o_uop  = r_busy ? w_uop : UOP_NOP;

endmodule

// ===== design/pidaw_datapath.sv =====
// Datapath: error history, integral with anti-windup, shared multiplier,
// accumulator and output limiter. Driven by control words; depends on pidaw_pkg.
module pidaw_datapath
    import pidaw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic signed [DW-1:0] i_measured,
    input  logic signed [DW-1:0] i_feedforward,
    input  logic signed [DW-1:0] i_setpoint,
    input  logic        [GW-1:0] i_kp,
    input  logic        [GW-1:0] i_ki,
    input  logic        [GW-1:0] i_kd,
    input  logic        [LW-1:0] i_lim,
    input  logic                 i_mode,
    input  logic        [QW-1:0] i_imax,
    input  t_uop                 i_uop,
    input  logic                 i_stall,
    output logic signed [DW-1:0] o_drive,
    output logic                 o_sat,
    output logic signed [EW-1:0] o_err
);

    logic signed [EW-1:0]   r_err;
    logic signed [DW-1:0]   r_ff;
    logic signed [EW:0]     r_d1;
    logic signed [EW+1:0]   r_d2;
    logic signed [IW-1:0]   r_integ;
    logic signed [EW-1:0]   r_prev_err;
    logic signed [EW-1:0]   r_prev2_err;
    logic signed [DW-1:0]   r_prev_drive;
    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc;
    logic signed [VW-1:0]   r_val;

    logic signed [EW-1:0]   w_err_new;
    logic        [GW-1:0]   w_gain;
    logic signed [IW-1:0]   w_opb;
    logic signed [DW-1:0]   w_lim16;
    logic signed [DW-1:0]   w_nlim16;
    logic                   w_hold;
    logic signed [IW-1:0]   w_imax;
    logic signed [AW-1:0]   w_acc_sh;
    logic signed [DW-1:0]   w_base;
    logic signed [VW-1:0]   w_lim_v;
    logic                   w_above, w_below;
    logic signed [DW-1:0]   w_drive;
    logic                   w_ki_zero;

    assign w_err_new = $signed({i_setpoint[DW-1], i_setpoint})
                     - $signed({i_measured[DW-1], i_measured});
    assign w_ki_zero = (i_ki == '0);
    assign w_lim16   = $signed({1'b0, i_lim});
    assign w_nlim16  = -w_lim16;
    assign w_hold    = (r_prev_drive >= w_lim16 && r_err > 0)
                    || (r_prev_drive <= w_nlim16 && r_err < 0);
    assign w_imax    = $signed({{(IW-QW){1'b0}}, i_imax});

    always_comb begin
        case (i_uop.gsel)
            G_KP:    w_gain = i_kp;
            G_KI:    w_gain = i_ki;
            default: w_gain = i_kd;
        endcase
        case (i_uop.osel)
            O_ERR:   w_opb = $signed({{(IW-EW){r_err[EW-1]}}, r_err});
            O_INTEG: w_opb = r_integ;
            O_D1:    w_opb = $signed({{(IW-EW-1){r_d1[EW]}}, r_d1});
            default: w_opb = $signed({{(IW-EW-2){r_d2[EW+1]}}, r_d2});
        endcase
    end

    // arithmetic shift gives the floor of the scaled sum
    assign w_acc_sh = r_acc >>> FRAC;
    assign w_base   = i_mode ? r_prev_drive : r_ff;

    assign w_lim_v  = $signed({{(VW-LW){1'b0}}, i_lim});
    assign w_above  = r_val > w_lim_v;
    assign w_below  = r_val < -w_lim_v;
    assign w_drive  = w_above ? w_lim16 : (w_below ? w_nlim16 : r_val[DW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err <= w_err_new;
            r_ff  <= i_feedforward;
        end
        if (i_uop.prep) begin
            r_d1  <= $signed({r_err[EW-1], r_err}) - $signed({r_prev_err[EW-1], r_prev_err});
            r_d2  <= $signed({{2{r_err[EW-1]}}, r_err})
                   - $signed({r_prev_err[EW-1], r_prev_err, 1'b0})
                   + $signed({{2{r_prev2_err[EW-1]}}, r_prev2_err});
        end
        if (i_uop.mul) begin
            r_prod <= $signed({1'b0, w_gain}) * w_opb;
        end
        if (i_uop.prep) begin
            r_acc <= '0;
        end else if (i_uop.acc) begin
            r_acc <= r_acc + $signed({{(AW-PW){r_prod[PW-1]}}, r_prod});
        end
        if (i_uop.sum) begin
            r_val <= $signed({{(VW-DW){w_base[DW-1]}}, w_base}) + w_acc_sh[VW-1:0];
        end
    end

    // controller history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ      <= '0;
            r_prev_err   <= '0;
            r_prev2_err  <= '0;
            r_prev_drive <= '0;
        end else begin
            if (i_uop.integ_add) begin
                if (w_ki_zero) begin
                    r_integ <= '0;
                end else if (!w_hold) begin
                    r_integ <= r_integ + $signed({{(IW-EW){r_err[EW-1]}}, r_err});
                end
            end
            if (i_uop.integ_clamp && !w_ki_zero) begin
                if (r_integ > w_imax) begin
                    r_integ <= w_imax;
                end else if (r_integ < -w_imax) begin
                    r_integ <= -w_imax;
                end
            end
            if (i_uop.fin && !i_stall) begin
                r_prev_drive <= w_drive;
                r_prev_err   <= r_err;
                if (i_mode) begin
                    r_prev2_err <= r_prev_err;
                end
            end
            if (i_uop.clr_out && !i_stall) begin
                r_integ      <= '0;
                r_prev_err   <= '0;
                r_prev2_err  <= '0;
                r_prev_drive <= '0;
            end
        end
    end

    assign o_drive = i_uop.clr_out ? '0 : w_drive;
    assign o_sat   = i_uop.clr_out ? 1'b0 : (w_above | w_below);
    assign o_err   = r_err;

endmodule
